FILE: src/ldm_pkg.sv
package ldm_pkg;

    localparam int LINE_CHARS_DEF  = 3;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [11:0] DEADBAND_RST = 12'd10;
    localparam logic [15:0] DEBOUNCE_RST = 16'd200;
    localparam logic [15:0] PERIOD_RST   = 16'd999;

    localparam logic [1:0] CFG_DEADBAND = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [1:0] CFG_PERIOD   = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0b;
    localparam logic [7:0] CH_FF    = 8'h0c;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [6:0] LEVEL_FULL = 7'd100;
    localparam logic [6:0] LEVEL_SAT  = 7'd101;
    localparam int         KNOB_SHIFT = 6;
    localparam int         KNOB_STEP  = 25;

    // x / 100 as (x * RECIP) >> RECIP_SHIFT, exact for x below 2^23
    localparam logic [23:0] RECIP       = 24'd10737419;
    localparam int          RECIP_SHIFT = 30;

    typedef enum logic [1:0] {
        OP_SERIAL = 2'd0,
        OP_BUTTON = 2'd1,
        OP_KNOB   = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SRC_NONE   = 2'd0,
        SRC_SERIAL = 2'd1,
        SRC_KNOB   = 2'd2,
        SRC_BUTTON = 2'd3
    } t_src;

    typedef struct packed {
        t_op         op;
        logic        eol;
        logic [7:0]  rx_byte;
        logic [31:0] stamp;
        logic [6:0]  knob_goal;
    } t_cmd;

    typedef struct packed {
        logic        valid;
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

    typedef struct packed {
        t_src        src;
        logic        lamp;
        logic [6:0]  goal;
        logic [6:0]  level;
        logic [16:0] cmp;
    } t_result;

    function automatic logic [6:0] knob_goal(input logic [1:0] step);
        knob_goal = 7'({5'd0, step} * 7'(KNOB_STEP));
    endfunction

endpackage

FILE: src/ldm_front.sv
module ldm_front #(
    parameter int SAMPLE_BITS = ldm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [1:0]             i_op,
    input  logic [7:0]             i_rx_byte,
    input  logic [31:0]            i_stamp,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_queue_full,
    output logic                   o_push,
    output ldm_pkg::t_cmd          o_cmd,
    output logic [SAMPLE_BITS-1:0] o_sample
);
    import ldm_pkg::*;

    localparam int HW = SAMPLE_BITS - KNOB_SHIFT;

    logic [HW-1:0] w_hi;

    assign s_axis_tready = !i_queue_full;
    assign o_push        = s_axis_tvalid && !i_queue_full;
    assign w_hi          = i_sample[SAMPLE_BITS-1:KNOB_SHIFT];

    always_comb begin
        o_cmd.op      = t_op'(i_op);
        o_cmd.eol     = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);
        o_cmd.rx_byte = i_rx_byte;
        o_cmd.stamp   = i_stamp;
        // sample / 64, clamped to the top step
        if (w_hi > HW'(3)) begin
            o_cmd.knob_goal = knob_goal(2'd3);
        end else begin
            o_cmd.knob_goal = knob_goal(w_hi[1:0]);
        end
    end

    assign o_sample = i_sample;

endmodule

FILE: src/ldm_queue.sv
module ldm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: src/ldm_back.sv
module ldm_back #(
    parameter int LINE_CHARS  = ldm_pkg::LINE_CHARS_DEF,
    parameter int SAMPLE_BITS = ldm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cmd_valid,
    input  ldm_pkg::t_cmd          i_cmd,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_pop,
    input  ldm_pkg::t_cfg_wr       i_cfg,
    output logic                   o_valid,
    input  logic                   i_ready,
    output ldm_pkg::t_result       o_result
);
    import ldm_pkg::*;

    localparam int LW = $clog2(LINE_CHARS + 1);
    localparam int IW = $clog2(LINE_CHARS);
    localparam int DW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;

    typedef enum logic [1:0] {
        PS_LEAD   = 2'd0,
        PS_DIGITS = 2'd1,
        PS_FAIL   = 2'd2
    } t_parse;

    // configuration
    logic [11:0] r_deadband;
    logic [15:0] r_debounce;
    logic [15:0] r_period;

    // control state
    logic [7:0]             r_chars [LINE_CHARS];
    logic [LW-1:0]          r_len;
    logic                   r_lamp;
    logic [6:0]             r_goal;
    logic [6:0]             r_level;
    t_src                   r_src;
    logic [SAMPLE_BITS-1:0] r_acc;
    logic [31:0]            r_last;

    logic [LW-1:0]          n_len;
    logic                   n_lamp;
    logic [6:0]             n_goal;
    logic [6:0]             n_level;
    t_src                   n_src;
    logic [SAMPLE_BITS-1:0] n_acc;
    logic [31:0]            n_last;
    logic                   w_char_we;

    // line parse
    logic [LW-1:0]          w_cnt;
    logic                   w_is_on;
    logic                   w_num_ok;
    logic                   w_neg;
    logic [6:0]             w_val;

    logic [31:0]            w_elapsed;
    logic [SAMPLE_BITS-1:0] w_diff;

    // result pipeline
    logic        w_en;
    logic        r_v1, r_v2, r_v3;
    t_result     r_s1, r_s2;
    logic [16:0] r_pp1;
    logic [23:0] r_prod;
    t_result     r_s3;
    logic [47:0] w_quot;

    assign w_en  = !r_v3 || i_ready;
    assign o_pop = w_en && i_cmd_valid;

    always_comb begin
        logic          stop;
        t_parse        pst;
        logic          dig;
        logic [10:0]   acc;
        logic [7:0]    c;
        stop  = 1'b0;
        acc   = '0;
        c     = '0;
        w_cnt = '0;
        for (int k = 0; k < LINE_CHARS; k++) begin
            if (!stop && (LW'(k) < r_len) && (r_chars[k] != 8'd0)) begin
                w_cnt = LW'(k + 1);
            end else begin
                stop = 1'b1;
            end
        end
        pst   = PS_LEAD;
        dig   = 1'b0;
        w_neg = 1'b0;
        w_val = 7'd0;
        for (int k = 0; k < LINE_CHARS; k++) begin
            c = r_chars[k];
            if (LW'(k) < w_cnt) begin
                case (pst)
                    PS_LEAD: begin
                        if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
                            pst = PS_LEAD;
                        end else if (c == CH_PLUS || c == CH_MINUS) begin
                            w_neg = (c == CH_MINUS);
                            pst   = PS_DIGITS;
                        end else if (c >= CH_ZERO && c <= CH_NINE) begin
                            acc   = 11'(w_val) * 11'd10 + 11'(c - CH_ZERO);
                            w_val = (acc > 11'(LEVEL_FULL)) ? LEVEL_SAT : acc[6:0];
                            dig   = 1'b1;
                            pst   = PS_DIGITS;
                        end else begin
                            pst = PS_FAIL;
                        end
                    end
                    PS_DIGITS: begin
                        if (c >= CH_ZERO && c <= CH_NINE) begin
                            acc   = 11'(w_val) * 11'd10 + 11'(c - CH_ZERO);
                            w_val = (acc > 11'(LEVEL_FULL)) ? LEVEL_SAT : acc[6:0];
                            dig   = 1'b1;
                        end else begin
                            pst = PS_FAIL;
                        end
                    end
                    default: begin
                        pst = PS_FAIL;
                    end
                endcase
            end
        end
        w_num_ok = dig && (pst != PS_FAIL);
        w_is_on  = (w_cnt == LW'(2)) && ((r_chars[0] | CASE_BIT) == CH_O)
                   && ((r_chars[1] | CASE_BIT) == CH_N);
    end

    assign w_elapsed = i_cmd.stamp - r_last;
    assign w_diff    = (i_sample >= r_acc) ? (i_sample - r_acc) : (r_acc - i_sample);

    always_comb begin
        n_len     = r_len;
        n_lamp    = r_lamp;
        n_goal    = r_goal;
        n_level   = r_level;
        n_src     = r_src;
        n_acc     = r_acc;
        n_last    = r_last;
        w_char_we = 1'b0;
        if (o_pop) begin
            case (i_cmd.op)
                OP_SERIAL: begin
                    if (i_cmd.eol) begin
                        n_len = '0;
                        if (w_cnt != '0) begin
                            if (w_is_on) begin
                                n_src = SRC_KNOB;
                            end else begin
                                if (w_num_ok) begin
                                    if (w_val == 7'd0) begin
                                        n_lamp = 1'b0;
                                        n_goal = 7'd0;
                                    end else if (!w_neg && w_val <= LEVEL_FULL) begin
                                        n_lamp = 1'b1;
                                        n_goal = w_val;
                                    end
                                end
                                n_src = SRC_SERIAL;
                            end
                        end
                    end else if (r_len < LW'(LINE_CHARS)) begin
                        w_char_we = 1'b1;
                        n_len     = r_len + LW'(1);
                    end
                end
                OP_BUTTON: begin
                    if (w_elapsed >= 32'(r_debounce)) begin
                        n_last = i_cmd.stamp;
                        n_lamp = ~r_lamp;
                        n_goal = r_lamp ? 7'd0 : LEVEL_FULL;
                        n_src  = SRC_BUTTON;
                    end
                end
                OP_KNOB: begin
                    if (r_src != SRC_SERIAL && r_src != SRC_BUTTON
                        && DW'(w_diff) >= DW'(r_deadband)) begin
                        n_acc  = i_sample;
                        n_goal = i_cmd.knob_goal;
                        n_lamp = (i_cmd.knob_goal != 7'd0);
                        n_src  = SRC_KNOB;
                    end
                end
                OP_TICK: begin
                    if (r_level < r_goal) begin
                        n_level = r_level + 7'd1;
                    end else if (r_level > r_goal) begin
                        n_level = r_level - 7'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_char_we) begin
            r_chars[r_len[IW-1:0]] <= i_cmd.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= DEADBAND_RST;
            r_debounce <= DEBOUNCE_RST;
            r_period   <= PERIOD_RST;
            r_len      <= '0;
            r_lamp     <= 1'b0;
            r_goal     <= 7'd0;
            r_level    <= 7'd0;
            r_src      <= SRC_NONE;
            r_acc      <= '0;
            r_last     <= 32'd0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_DEADBAND: r_deadband <= i_cfg.data[11:0];
                    CFG_DEBOUNCE: r_debounce <= i_cfg.data;
                    CFG_PERIOD:   r_period   <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            r_len   <= n_len;
            r_lamp  <= n_lamp;
            r_goal  <= n_goal;
            r_level <= n_level;
            r_src   <= n_src;
            r_acc   <= n_acc;
            r_last  <= n_last;
        end
    end

    // compare value: (period + 1) * level, then divide by 100
    assign w_quot = 48'(r_prod) * 48'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1.src   <= n_src;
            r_s1.lamp  <= n_lamp;
            r_s1.goal  <= n_goal;
            r_s1.level <= n_level;
            r_s1.cmp   <= '0;
            r_pp1      <= 17'(r_period) + 17'd1;
            r_s2       <= r_s1;
            r_prod     <= 24'(r_pp1) * 24'(r_s1.level);
            r_s3.src   <= r_s2.src;
            r_s3.lamp  <= r_s2.lamp;
            r_s3.goal  <= r_s2.goal;
            r_s3.level <= r_s2.level;
            r_s3.cmp   <= w_quot[RECIP_SHIFT+16:RECIP_SHIFT];
        end
    end

    assign o_valid  = r_v3;
    assign o_result = r_s3;

endmodule

FILE: src/led_dimmer_multi_source_control.sv
// a result passes through the queue, then the registers r_s1, r_s2 and r_s3, before it leaves
// throughput: one word per cycle while the output does not stall, set by the registered state update in the back end
// a 2-entry queue decouples input acceptance from the back end and output stall
// reset: synchronous active low, clears the control state but the line buffer and loads register defaults
module led_dimmer_multi_source_control #(
    parameter int LINE_CHARS  = ldm_pkg::LINE_CHARS_DEF,
    parameter int SAMPLE_BITS = ldm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // rx_byte[7:0], press_time_ms[39:8], knob_sample from bit 40, zero fill
    input  logic [((40 + SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                             s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // pwm_compare[16:0], current_level[23:17], target_level[30:24],
    // lamp_on[31], control_source[33:32], zero fill
    output logic [39:0]                            m_axis_tdata,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [1:0]                             i_cfg_index,
    input  logic [15:0]                            i_cfg_data
);
    import ldm_pkg::*;

    localparam int QW = $bits(t_cmd) + SAMPLE_BITS;

    logic                   w_full;
    logic                   w_empty;
    logic                   w_push;
    logic                   w_pop;
    t_cmd                   w_front_cmd;
    logic [SAMPLE_BITS-1:0] w_front_sample;
    logic [QW-1:0]          w_q_out;
    t_cmd                   w_back_cmd;
    logic [SAMPLE_BITS-1:0] w_back_sample;
    t_cfg_wr                w_cfg;
    t_result                w_result;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    ldm_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .i_op         (s_axis_tuser),
        .i_rx_byte    (s_axis_tdata[7:0]),
        .i_stamp      (s_axis_tdata[39:8]),
        .i_sample     (s_axis_tdata[40 +: SAMPLE_BITS]),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd),
        .o_sample     (w_front_sample)
    );

    ldm_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_data ({w_front_sample, w_front_cmd}),
        .i_pop  (w_pop),
        .o_data (w_q_out),
        .o_full (w_full),
        .o_empty(w_empty)
    );

    assign w_back_cmd    = w_q_out[$bits(t_cmd)-1:0];
    assign w_back_sample = w_q_out[QW-1:$bits(t_cmd)];

    ldm_back #(
        .LINE_CHARS (LINE_CHARS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(!w_empty),
        .i_cmd      (w_back_cmd),
        .i_sample   (w_back_sample),
        .o_pop      (w_pop),
        .i_cfg      (w_cfg),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (w_result)
    );

    assign m_axis_tdata = {6'd0, w_result};

endmodule

FILE: sim/led_dimmer_multi_source_control_tb.sv
`timescale 1ns / 100ps

module led_dimmer_multi_source_control_tb;
    import ldm_pkg::*;

    localparam int TDATA_W        = ((40 + SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int SETTLE_CYCLES  = 8;
    localparam int KNOB_STEPS_MAX = 3;
    localparam int PRINT_LIMIT    = 40;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [7:0] CH_NUL    = 8'h00;

    class dimmer_scoreboard;
        t_result     status_q[$];
        logic [11:0] deadband;
        logic [15:0] debounce;
        logic [15:0] period;
        logic [7:0]  line_buf[LINE_CHARS_DEF];
        int unsigned line_len;
        logic        lamp;
        logic [6:0]  goal;
        logic [6:0]  level;
        t_src        src;
        logic [11:0] last_sample;
        logic [31:0] last_stamp;
        int          errors;
        int          checked;
        int          lines_run;
        int          op_count[4];

        function new();
            deadband    = DEADBAND_RST;
            debounce    = DEBOUNCE_RST;
            period      = PERIOD_RST;
            line_len    = 0;
            lamp        = 1'b0;
            goal        = '0;
            level       = '0;
            src         = SRC_NONE;
            last_sample = '0;
            last_stamp  = '0;
            errors      = 0;
            checked     = 0;
            lines_run   = 0;
            foreach (op_count[i]) op_count[i] = 0;
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [15:0] data);
            case (idx)
                CFG_DEADBAND: deadband = data[11:0];
                CFG_DEBOUNCE: debounce = data;
                CFG_PERIOD:   period = data;
                default: ;
            endcase
        endfunction

        function void run_line();
            int unsigned n;
            int unsigned i;
            int unsigned digits;
            int unsigned value;
            bit          neg;
            n = 0;
            i = 0;
            digits = 0;
            value = 0;
            neg = 1'b0;
            lines_run++;
            while (n < line_len && n < LINE_CHARS_DEF && line_buf[n] != CH_NUL) n++;
            if (n == 0) return;
            if (n == 2 && (line_buf[0] | CASE_BIT) == CH_O
                && (line_buf[1] | CASE_BIT) == CH_N) begin
                src = SRC_KNOB;
                return;
            end
            while (i < n && (line_buf[i] == CH_SPACE || line_buf[i] == CH_TAB ||
                             line_buf[i] == CH_VT || line_buf[i] == CH_FF)) i++;
            if (i < n && (line_buf[i] == CH_PLUS || line_buf[i] == CH_MINUS)) begin
                neg = (line_buf[i] == CH_MINUS);
                i++;
            end
            while (i < n && line_buf[i] >= CH_ZERO && line_buf[i] <= CH_NINE) begin
                if (value < 100000) value = value * 10 + 32'(line_buf[i] - CH_ZERO);
                digits++;
                i++;
            end
            if (digits > 0 && i == n) begin
                if (value == 0) begin
                    lamp = 1'b0;
                    goal = '0;
                end else if (!neg && value <= LEVEL_FULL) begin
                    lamp = 1'b1;
                    goal = 7'(value);
                end
            end
            src = SRC_SERIAL;
        endfunction

        function void note_event(input t_op op, input logic [7:0] rx, input logic [31:0] stamp,
                                 input logic [11:0] sample);
            logic [31:0] since;
            logic [11:0] diff;
            logic [5:0]  knob_step;
            int unsigned prod;
            t_result     want;
            op_count[op]++;
            case (op)
                OP_SERIAL: begin
                    if (rx == CH_CR || rx == CH_LF) begin
                        run_line();
                        line_len = 0;
                    end else if (line_len < LINE_CHARS_DEF) begin
                        line_buf[line_len] = rx;
                        line_len++;
                    end
                end
                OP_BUTTON: begin
                    since = stamp - last_stamp;
                    if (since >= {16'd0, debounce}) begin
                        last_stamp = stamp;
                        lamp = ~lamp;
                        goal = lamp ? LEVEL_FULL : 7'd0;
                        src = SRC_BUTTON;
                    end
                end
                OP_KNOB: begin
                    if (src != SRC_SERIAL && src != SRC_BUTTON) begin
                        diff = (sample >= last_sample) ? sample - last_sample
                                                       : last_sample - sample;
                        if (diff >= deadband) begin
                            last_sample = sample;
                            knob_step = 6'(sample >> KNOB_SHIFT);
                            if (knob_step > 6'(KNOB_STEPS_MAX)) knob_step = 6'(KNOB_STEPS_MAX);
                            goal = 7'(knob_step * KNOB_STEP);
                            lamp = (goal != 0);
                            src = SRC_KNOB;
                        end
                    end
                end
                default: begin
                    if (level < goal) level++;
                    else if (level > goal) level--;
                end
            endcase
            prod = (int'(period) + 1) * int'(level);
            want.cmp   = 17'(prod / LEVEL_FULL);
            want.level = level;
            want.goal  = goal;
            want.lamp  = lamp;
            want.src   = src;
            status_q.push_back(want);
        endfunction

        task report(input string what, input longint unsigned got_v, input longint unsigned want_v);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("%0t mismatch %s: got %0d expected %0d", $time, what, got_v, want_v);
        endtask

        task check_status(input logic [39:0] word);
            t_result got;
            t_result want;
            got = t_result'(word[33:0]);
            if (status_q.size() == 0) begin
                report("status word with nothing expected", word, 0);
                return;
            end
            want = status_q.pop_front();
            checked++;
            if (got.cmp != want.cmp) report("pwm_compare", got.cmp, want.cmp);
            if (got.level != want.level) report("current_level", got.level, want.level);
            if (got.goal != want.goal) report("target_level", got.goal, want.goal);
            if (got.lamp != want.lamp) report("lamp_on", got.lamp, want.lamp);
            if (got.src != want.src) report("control_source", got.src, want.src);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata = '0;
    logic [1:0]         s_axis_tuser = OP_SERIAL;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = CFG_DEADBAND;
    logic [15:0]        i_cfg_data = '0;

    dimmer_scoreboard sb = new();
    logic [7:0]       line_q[$];
    int               word_count = 0;
    int               burst_left = 0;
    int               reg_writes = 0;
    int               settings_count = 1;
    logic [9:0]       stall_cnt = '0;

    led_dimmer_multi_source_control i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 10'd1;
        case (stall_cnt[8:7])
            2'd0: m_axis_tready <= 1'b1;
            2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
            2'd2: m_axis_tready <= (stall_cnt[1:0] == 2'd0);
            default: m_axis_tready <= (stall_cnt[4:3] != 2'b11);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_event(input t_op op, input logic [31:0] arg);
        logic [TDATA_W-1:0] w;
        int                 gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else if (word_count % 97 == 96) begin
            // hold off until the block has drained
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while (sb.pending() != 0);
        end
        burst_left--;
        w = '0;
        w[7:0]  = (op == OP_SERIAL) ? arg[7:0] : 8'($urandom);
        w[39:8] = (op == OP_BUTTON) ? arg : 32'($urandom);
        w[40 +: SAMPLE_BITS_DEF] = (op == OP_KNOB) ? arg[SAMPLE_BITS_DEF-1:0]
                                                   : SAMPLE_BITS_DEF'($urandom);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_event(op, w[7:0], w[39:8], w[40 +: SAMPLE_BITS_DEF]);
        word_count++;
    endtask

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endfunction

    task automatic send_line_q();
        while (line_q.size() != 0) send_event(OP_SERIAL, {24'd0, line_q.pop_front()});
    endtask

    task automatic wait_idle(input int settle);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] db, input logic [15:0] deb,
                             input logic [15:0] per, input bit spare);
        logic [1:0]  idx[4];
        logic [15:0] vals[4];
        int          last_idx;
        idx[0] = CFG_DEADBAND;
        idx[1] = CFG_DEBOUNCE;
        idx[2] = CFG_PERIOD;
        idx[3] = CFG_SPARE;
        vals[0] = db;
        vals[1] = deb;
        vals[2] = per;
        vals[3] = 16'($urandom);
        last_idx = spare ? 3 : 2;
        for (int i = 0; i <= last_idx; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= vals[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.write_reg(idx[i], vals[i]);
            reg_writes++;
        end
        i_cfg_valid <= 1'b0;
        settings_count++;
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    task automatic send_random_line();
        int v;
        int k;
        case ($urandom_range(0, 9))
            0: begin
                line_q.push_back($urandom_range(0, 1) ? CH_O : (CH_O & ~CASE_BIT));
                line_q.push_back($urandom_range(0, 1) ? CH_N : (CH_N & ~CASE_BIT));
            end
            1, 2, 3: begin
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                repeat (k) line_q.push_back(pick_blank());
                k = $urandom_range(0, 3);
                if (k == 1) line_q.push_back(CH_PLUS);
                if (k == 2) line_q.push_back(CH_MINUS);
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = $urandom_range(1, 100);
                    2: v = $urandom_range(101, 999);
                    default: v = $urandom_range(0, 100);
                endcase
                add_text($sformatf("%0d", v));
            end
            4: ;
            5: repeat ($urandom_range(1, 5)) line_q.push_back(8'($urandom));
            6: begin
                line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                line_q.push_back(CH_NUL);
                if ($urandom_range(0, 1)) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            7: repeat ($urandom_range(4, 7)) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            8: begin
                line_q.push_back(CH_O);
                line_q.push_back(8'($urandom));
            end
            default: begin
                if ($urandom_range(0, 1)) line_q.push_back(pick_blank());
                add_text("On");
                if ($urandom_range(0, 1)) line_q.push_back(8'($urandom));
            end
        endcase
        line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        send_line_q();
    endtask

    task automatic press_button();
        int unsigned d;
        int unsigned deb;
        deb = 32'(sb.debounce);
        case ($urandom_range(0, 4))
            0: d = (deb == 0) ? 0 : deb - 1;
            1: d = deb;
            2: d = deb + $urandom_range(0, 50);
            3: d = $urandom_range(0, deb);
            default: d = $urandom;
        endcase
        send_event(OP_BUTTON, sb.last_stamp + d);
    endtask

    task automatic turn_knob();
        int s;
        int db;
        if ((sb.src == SRC_SERIAL || sb.src == SRC_BUTTON) && $urandom_range(0, 2) == 0) begin
            add_text("ON");
            line_q.push_back(CH_CR);
            send_line_q();
        end
        db = int'(sb.deadband);
        case ($urandom_range(0, 5))
            0: s = 0;
            1: s = SAMPLE_MAX;
            2: s = int'(sb.last_sample) + db - $urandom_range(0, 1);
            3: s = int'(sb.last_sample) - db + $urandom_range(0, 1);
            4: s = (1 << KNOB_SHIFT) * $urandom_range(1, 3) - $urandom_range(0, 1);
            default: s = $urandom_range(0, SAMPLE_MAX);
        endcase
        if (s < 0) s = 0;
        if (s > SAMPLE_MAX) s = SAMPLE_MAX;
        send_event(OP_KNOB, 32'(s));
    endtask

    task automatic run_random(input int words);
        int target;
        int r;
        target = word_count + words;
        while (word_count < target) begin
            r = $urandom_range(0, 99);
            if (r < 35) send_random_line();
            else if (r < 55) press_button();
            else if (r < 75) turn_knob();
            else if (r < 95) repeat ($urandom_range(1, 20)) send_event(OP_TICK, 0);
            else send_event(OP_SERIAL, $urandom);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_event(OP_TICK, 0);
        send_event(OP_KNOB, SAMPLE_MAX);
        send_event(OP_TICK, 0);
        send_event(OP_KNOB, SAMPLE_MAX - 5);
        send_event(OP_KNOB, 100);
        // press too soon after reset, then one right at the debounce edge
        send_event(OP_BUTTON, 150);
        send_event(OP_BUTTON, 200);
        send_event(OP_KNOB, 0);
        add_text("oN");
        line_q.push_back(CH_CR);
        line_q.push_back(CH_CR);
        add_text("1005");
        line_q.push_back(CH_LF);
        add_text("-0");
        line_q.push_back(CH_LF);
        line_q.push_back(CH_TAB);
        add_text("9");
        line_q.push_back(CH_CR);
        add_text("5");
        line_q.push_back(CH_NUL);
        line_q.push_back(CH_LF);
        send_line_q();
        // stamp wrap around
        send_event(OP_BUTTON, 32'hffff_ffff);
        send_event(OP_BUTTON, 32'h0000_0050);
        send_event(OP_TICK, 0);

        run_random(140);

        s_axis_tvalid <= 1'b0;
        wait_idle(SETTLE_CYCLES);
        configure(16'd0, 16'd0, 16'd0, 1'b0);
        run_random(140);

        s_axis_tvalid <= 1'b0;
        wait_idle(SETTLE_CYCLES);
        configure(16'hffff, 16'hffff, 16'hffff, 1'b1);
        run_random(140);

        s_axis_tvalid <= 1'b0;
        wait_idle(SETTLE_CYCLES);
        configure(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        run_random(140);

        s_axis_tvalid <= 1'b0;
        wait_idle(SETTLE_CYCLES);
        configure(16'($urandom_range(1, 40)), 16'($urandom_range(1, 500)),
                  16'($urandom), 1'b0);
        run_random(140);

        s_axis_tvalid <= 1'b0;
        wait_idle(SETTLE_CYCLES);

        $display("checked %0d status words: %0d serial bytes in %0d lines, %0d presses,",
                 sb.checked, sb.op_count[OP_SERIAL], sb.lines_run, sb.op_count[OP_BUTTON]);
        $display("%0d knob, %0d ticks, %0d register writes over %0d settings, %0d mismatches",
                 sb.op_count[OP_KNOB], sb.op_count[OP_TICK], reg_writes, settings_count,
                 sb.errors);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
